FILE: design/pmsc_pkg.sv
package pmsc_pkg;

    localparam int ANGLE_BITS_DEF   = 32;
    localparam int CORDIC_STEPS_DEF = 32;

    localparam int FRAC = 30;
    localparam int VW   = 34;
    localparam int QB   = FRAC + 1;

    typedef logic signed [VW-1:0] t_vec;

    localparam t_vec ONE   = t_vec'(64'd1 << FRAC);
    localparam t_vec KGAIN = t_vec'(64'd652032874);

    localparam logic [63:0] INV2PI = 64'h28BE60DB9391054A;
    localparam logic signed [2*VW-1:0] FMUL_RND = (2*VW)'(64'd1 << (FRAC - 1));

    function automatic t_vec fmul(input t_vec a, input t_vec b);
        logic signed [2*VW-1:0] p;
        p = a * b;
        p = p + FMUL_RND;
        return t_vec'(p >>> FRAC);
    endfunction

    function automatic logic [63:0] cordic_angle(input int idx, input int ab);
        logic [63:0]  sum;
        logic [63:0]  term;
        logic [63:0]  turns;
        logic [127:0] prod;
        int           k;
        sum = '0;
        if (idx == 0) begin
            turns = 64'h2000_0000_0000_0000;
        end else begin
            for (k = 0; idx * (2 * k + 1) <= 63; k++) begin
                term = (64'd1 << (63 - idx * (2 * k + 1))) / 64'(2 * k + 1);
                if ((k & 1) == 0) begin
                    sum = sum + term;
                end else begin
                    sum = sum - term;
                end
            end
            prod  = {64'd0, sum} * {64'd0, INV2PI};
            turns = prod[126:63];
        end
        return (turns + (64'd1 << (63 - ab))) >> (64 - ab);
    endfunction

endpackage

FILE: design/pmsc_cordic_rot.sv
module pmsc_cordic_rot
    import pmsc_pkg::*;
#(
    parameter int AW    = ANGLE_BITS_DEF,
    parameter int STEPS = CORDIC_STEPS_DEF,
    parameter int LANES = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [AW-1:0] i_angle [LANES],
    output logic                 o_valid,
    output t_vec                 o_sin   [LANES],
    output t_vec                 o_cos   [LANES]
);

    localparam int ZR = AW + 1;
    localparam logic signed [ZR-1:0] HALF    = ZR'(64'd1 << (AW - 1));
    localparam logic signed [ZR-1:0] QUARTER = HALF >>> 1;

    logic signed [ZR-1:0] r_z   [STEPS+1][LANES];
    t_vec                 r_x   [STEPS+1][LANES];
    t_vec                 r_y   [STEPS+1][LANES];
    logic [LANES-1:0]     r_neg [STEPS+1];
    logic [STEPS+1:0]     r_v;
    t_vec                 r_sin [LANES];
    t_vec                 r_cos [LANES];

    logic signed [ZR-1:0] n_z   [LANES];
    logic [LANES-1:0]     n_neg;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_z[l]   = ZR'(i_angle[l]);
            n_neg[l] = 1'b0;
            if (n_z[l] > QUARTER) begin
                n_z[l]   = n_z[l] - HALF;
                n_neg[l] = 1'b1;
            end else if (n_z[l] < -QUARTER) begin
                n_z[l]   = n_z[l] + HALF;
                n_neg[l] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                r_z[0][l] <= n_z[l];
                r_x[0][l] <= KGAIN;
                r_y[0][l] <= '0;
            end
            r_neg[0] <= n_neg;
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_it
        localparam logic signed [ZR-1:0] TAB = ZR'(cordic_angle(g, AW));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < LANES; l++) begin
                    if (r_z[g][l] >= 0) begin
                        r_x[g+1][l] <= r_x[g][l] - (r_y[g][l] >>> g);
                        r_y[g+1][l] <= r_y[g][l] + (r_x[g][l] >>> g);
                        r_z[g+1][l] <= r_z[g][l] - TAB;
                    end else begin
                        r_x[g+1][l] <= r_x[g][l] + (r_y[g][l] >>> g);
                        r_y[g+1][l] <= r_y[g][l] - (r_x[g][l] >>> g);
                        r_z[g+1][l] <= r_z[g][l] + TAB;
                    end
                end
                r_neg[g+1] <= r_neg[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                r_sin[l] <= r_neg[STEPS][l] ? -r_y[STEPS][l] : r_y[STEPS][l];
                r_cos[l] <= r_neg[STEPS][l] ? -r_x[STEPS][l] : r_x[STEPS][l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STEPS:0], i_valid};
        end
    end

    assign o_valid = r_v[STEPS+1];
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;

endmodule

FILE: design/pmsc_cordic_vec.sv
module pmsc_cordic_vec
    import pmsc_pkg::*;
#(
    parameter int AW    = ANGLE_BITS_DEF,
    parameter int STEPS = CORDIC_STEPS_DEF,
    parameter int TW    = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_vec                 i_y,
    input  t_vec                 i_x,
    input  logic [TW-1:0]        i_tag,
    output logic                 o_valid,
    output logic signed [AW+1:0] o_angle,
    output t_vec                 o_len,
    output logic [TW-1:0]        o_tag
);

    localparam int ZW = AW + 2;
    localparam logic signed [ZW-1:0] HALF = ZW'(64'd1 << (AW - 1));

    logic signed [ZW-1:0] r_z [STEPS+1];
    t_vec                 r_x [STEPS+1];
    t_vec                 r_y [STEPS+1];
    logic [TW-1:0]        r_t [STEPS+2];
    logic [STEPS+1:0]     r_v;
    logic signed [ZW-1:0] r_ang;
    t_vec                 r_len;

    logic signed [ZW-1:0] n_z;
    t_vec                 n_x;
    t_vec                 n_y;

    always_comb begin
        n_z = '0;
        n_x = i_x;
        n_y = i_y;
        if (i_x < 0) begin
            n_z = (i_y >= 0) ? HALF : -HALF;
            n_x = -i_x;
            n_y = -i_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z[0] <= n_z;
            r_x[0] <= n_x;
            r_y[0] <= n_y;
            r_t[0] <= i_tag;
            for (int j = 0; j <= STEPS; j++) begin
                r_t[j+1] <= r_t[j];
            end
            r_ang <= r_z[STEPS];
            r_len <= fmul(r_x[STEPS], KGAIN);
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_it
        localparam logic signed [ZW-1:0] TAB = ZW'(cordic_angle(g, AW));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[g] >= 0) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + TAB;
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - TAB;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STEPS:0], i_valid};
        end
    end

    assign o_valid = r_v[STEPS+1];
    assign o_angle = r_ang;
    assign o_len   = r_len;
    assign o_tag   = r_t[STEPS+1];

endmodule

FILE: design/pmsc_divider.sv
module pmsc_divider
    import pmsc_pkg::*;
#(
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  t_vec          i_num [2],
    input  t_vec          i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output t_vec          o_quo [2],
    output logic [TW-1:0] o_tag
);

    localparam int RW = VW + 31;
    localparam logic [QB-1:0] ONE_Q = QB'(64'd1 << FRAC);

    logic [RW-1:0] r_rem [QB+1][2];
    logic [QB-1:0] r_q   [QB+1][2];
    logic [1:0]    r_neg [QB+1];
    logic [1:0]    r_sat [QB+1];
    logic [VW-2:0] r_den [QB+1];
    logic [TW-1:0] r_t   [QB+2];
    logic [QB+1:0] r_v;
    t_vec          r_quo [2];

    logic [VW-1:0] n_mag [2];
    logic [1:0]    n_sat;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_mag[l] = i_num[l][VW-1] ? VW'(-i_num[l]) : VW'(i_num[l]);
            n_sat[l] = {1'b0, n_mag[l]} >= {1'b0, i_den[VW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                r_rem[0][l] <= RW'(n_mag[l]) << FRAC;
                r_q[0][l]   <= '0;
                r_neg[0][l] <= i_num[l][VW-1];
            end
            r_sat[0] <= n_sat;
            r_den[0] <= i_den[VW-2:0];
            r_t[0]   <= i_tag;
            for (int j = 0; j <= QB; j++) begin
                r_t[j+1] <= r_t[j];
            end
            for (int l = 0; l < 2; l++) begin
                if (r_sat[QB][l] || (r_q[QB][l] > ONE_Q)) begin
                    r_quo[l] <= r_neg[QB][l] ? -ONE : ONE;
                end else begin
                    r_quo[l] <= r_neg[QB][l] ? -t_vec'(r_q[QB][l]) : t_vec'(r_q[QB][l]);
                end
            end
        end
    end

    for (genvar g = 0; g < QB; g++) begin : g_it
        localparam int K = QB - 1 - g;
        logic [RW-1:0] w_dsh;
        assign w_dsh = RW'(r_den[g]) << K;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 2; l++) begin
                    if (r_rem[g][l] >= w_dsh) begin
                        r_rem[g+1][l] <= r_rem[g][l] - w_dsh;
                        r_q[g+1][l]   <= {r_q[g][l][QB-2:0], 1'b1};
                    end else begin
                        r_rem[g+1][l] <= r_rem[g][l];
                        r_q[g+1][l]   <= {r_q[g][l][QB-2:0], 1'b0};
                    end
                end
                r_neg[g+1] <= r_neg[g];
                r_sat[g+1] <= r_sat[g];
                r_den[g+1] <= r_den[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QB:0], i_valid};
        end
    end

    assign o_valid = r_v[QB+1];
    assign o_quo   = r_quo;
    assign o_tag   = r_t[QB+1];

endmodule

FILE: design/polar_motion_site_correction_top.sv
// Polar motion site correction: one item of site longitude, latitude and pole offsets x, y
// (binary angles, full range = +/-pi) gives one item of true longitude, true latitude and
// azimuth correction. A new item is taken every clock while the pipeline is not halted; the
// result passes through four unrolled CORDIC chains (sine and cosine of the inputs, then three
// arctangents) and a 31-stage restoring divider in series. The pipeline halts as a whole only
// while its two-entry output buffer is full.
module polar_motion_site_correction_top
    import pmsc_pkg::*;
#(
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // mean_longitude, mean_latitude, pole_offset_x, pole_offset_y
    input  logic [127:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // true_longitude, true_latitude, azimuth_correction
    output logic [95:0]  o_m_axis_tdata
);

    localparam int AW   = ANGLE_BITS;
    localparam int ZW   = AW + 2;
    localparam int OW   = AW + 36;
    localparam int SHL  = (AW >= 32) ? AW - 32 : 0;
    localparam int SHR  = (AW < 32) ? 32 - AW : 0;
    localparam int OSH  = (AW > 32) ? AW - 32 : 0;
    localparam int OSL  = (AW < 32) ? 32 - AW : 0;
    localparam int RSH  = (OSH > 0) ? OSH - 1 : 0;
    localparam logic signed [OW-1:0] ORND = (OSH > 0) ? (OW'(1) << RSH) : '0;

    typedef struct packed {
        t_vec zt;
        t_vec xt;
        t_vec yt;
        t_vec xnm;
        t_vec ynm;
        t_vec znm;
    } t_tag1;

    typedef struct packed {
        logic signed [ZW-1:0] elong;
        t_vec zt;
        t_vec len;
        t_vec xnm;
        t_vec ynm;
        t_vec znm;
    } t_tagd;

    typedef struct packed {
        logic signed [ZW-1:0] elong;
        t_vec zt;
        t_vec len;
        t_vec sel;
        t_vec cel;
        t_vec xnm;
        t_vec ynm;
        t_vec znm;
    } t_tag2;

    typedef struct packed {
        logic signed [ZW-1:0] elong;
        logic signed [ZW-1:0] phi;
        logic                 nz;
    } t_tag3;

    function automatic logic signed [AW-1:0] in_angle(input logic [31:0] f);
        logic signed [AW+31:0] w;
        w = (AW+32)'(signed'(f));
        w = (w <<< SHL) >>> SHR;
        return w[AW-1:0];
    endfunction

    function automatic logic [31:0] out_angle(input logic signed [ZW-1:0] z);
        logic signed [OW-1:0] w;
        w = OW'(z);
        w = ((w + ORND) >>> OSH) <<< OSL;
        return w[31:0];
    endfunction

    logic en;
    logic r_skid_v;
    logic r_ov;
    logic [95:0] r_skid;
    logic [95:0] r_odata;

    assign en = !r_skid_v;
    assign o_s_axis_tready = en;

    logic signed [AW-1:0] w_ang [4];
    logic rot_v;
    t_vec rot_s [4];
    t_vec rot_c [4];

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            w_ang[l] = in_angle(i_s_axis_tdata[32*l +: 32]);
        end
    end

    pmsc_cordic_rot #(.AW(AW), .STEPS(CORDIC_STEPS), .LANES(4)) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_angle (w_ang),
        .o_valid (rot_v),
        .o_sin   (rot_s),
        .o_cos   (rot_c)
    );

    logic r_p1_v, r_p2_v, r_p3_v, r_q_v, r_t1_v, r_t2_v, r_tail_v;
    t_vec r_p1_xm, r_p1_ym, r_p1_zm, r_p1_xnm, r_p1_ynm, r_p1_znm;
    t_vec r_p1_cx, r_p1_sx, r_p1_cy, r_p1_sy;
    t_vec r_p2_zw, r_p2_yt, r_p2_xm, r_p2_cx, r_p2_sx, r_p2_xnm, r_p2_ynm, r_p2_znm;
    t_vec r_p3_xt, r_p3_zt, r_p3_yt, r_p3_xnm, r_p3_ynm, r_p3_znm;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_xm  <= fmul(rot_c[0], rot_c[1]);
            r_p1_ym  <= fmul(rot_s[0], rot_c[1]);
            r_p1_zm  <= rot_s[1];
            r_p1_xnm <= -fmul(rot_s[2], rot_c[3]);
            r_p1_ynm <= rot_s[3];
            r_p1_znm <= fmul(rot_c[2], rot_c[3]);
            r_p1_cx  <= rot_c[2];
            r_p1_sx  <= rot_s[2];
            r_p1_cy  <= rot_c[3];
            r_p1_sy  <= rot_s[3];

            r_p2_zw  <= fmul(r_p1_zm, r_p1_cy) - fmul(r_p1_ym, r_p1_sy);
            r_p2_yt  <= fmul(r_p1_ym, r_p1_cy) + fmul(r_p1_zm, r_p1_sy);
            r_p2_xm  <= r_p1_xm;
            r_p2_cx  <= r_p1_cx;
            r_p2_sx  <= r_p1_sx;
            r_p2_xnm <= r_p1_xnm;
            r_p2_ynm <= r_p1_ynm;
            r_p2_znm <= r_p1_znm;

            r_p3_xt  <= fmul(r_p2_xm, r_p2_cx) - fmul(r_p2_zw, r_p2_sx);
            r_p3_zt  <= fmul(r_p2_xm, r_p2_sx) + fmul(r_p2_zw, r_p2_cx);
            r_p3_yt  <= r_p2_yt;
            r_p3_xnm <= r_p2_xnm;
            r_p3_ynm <= r_p2_ynm;
            r_p3_znm <= r_p2_znm;
        end
    end

    t_tag1 w_tag1_in, v1_tag;
    logic  v1_v;
    logic signed [ZW-1:0] v1_ang;
    t_vec  v1_len;

    assign w_tag1_in = '{zt: r_p3_zt, xt: r_p3_xt, yt: r_p3_yt,
                         xnm: r_p3_xnm, ynm: r_p3_ynm, znm: r_p3_znm};

    pmsc_cordic_vec #(.AW(AW), .STEPS(CORDIC_STEPS), .TW($bits(t_tag1))) u_vec_lon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p3_v),
        .i_y     (r_p3_yt),
        .i_x     (r_p3_xt),
        .i_tag   (w_tag1_in),
        .o_valid (v1_v),
        .o_angle (v1_ang),
        .o_len   (v1_len),
        .o_tag   (v1_tag)
    );

    logic  w_nz1;
    t_tagd r_q_tag;
    t_vec  r_q_xt, r_q_yt;

    assign w_nz1 = (v1_tag.xt != '0) || (v1_tag.yt != '0);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q_tag.elong <= w_nz1 ? v1_ang : '0;
            r_q_tag.len   <= w_nz1 ? v1_len : '0;
            r_q_tag.zt    <= v1_tag.zt;
            r_q_tag.xnm   <= v1_tag.xnm;
            r_q_tag.ynm   <= v1_tag.ynm;
            r_q_tag.znm   <= v1_tag.znm;
            r_q_xt        <= v1_tag.xt;
            r_q_yt        <= v1_tag.yt;
        end
    end

    t_vec  w_num [2];
    t_vec  d_quo [2];
    t_tagd d_tag;
    logic  d_v;

    assign w_num[0] = r_q_yt;
    assign w_num[1] = r_q_xt;

    pmsc_divider #(.TW($bits(t_tagd))) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_q_v),
        .i_num   (w_num),
        .i_den   (r_q_tag.len),
        .i_tag   (r_q_tag),
        .o_valid (d_v),
        .o_quo   (d_quo),
        .o_tag   (d_tag)
    );

    t_tag2 w_tag2_in, v2_tag;
    logic  w_len0;
    logic  v2_v;
    logic signed [ZW-1:0] v2_ang;

    assign w_len0 = (d_tag.len == '0);
    assign w_tag2_in = '{elong: d_tag.elong, zt: d_tag.zt, len: d_tag.len,
                         sel: (w_len0 ? t_vec'(0) : d_quo[0]),
                         cel: (w_len0 ? ONE : d_quo[1]),
                         xnm: d_tag.xnm, ynm: d_tag.ynm, znm: d_tag.znm};

    pmsc_cordic_vec #(.AW(AW), .STEPS(CORDIC_STEPS), .TW($bits(t_tag2))) u_vec_lat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_v),
        .i_y     (d_tag.zt),
        .i_x     (d_tag.len),
        .i_tag   (w_tag2_in),
        .o_valid (v2_v),
        .o_angle (v2_ang),
        .o_len   (),
        .o_tag   (v2_tag)
    );

    t_vec r_t1_a, r_t1_b, r_t1_ynt, r_t1_zt;
    t_vec r_t2_xnt, r_t2_ynt;
    logic signed [ZW-1:0] r_t1_elong, r_t1_phi, r_t2_elong, r_t2_phi;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1_a     <= fmul(v2_tag.xnm, v2_tag.cel) + fmul(v2_tag.ynm, v2_tag.sel);
            r_t1_b     <= fmul(v2_tag.znm, v2_tag.len);
            r_t1_ynt   <= fmul(v2_tag.ynm, v2_tag.cel) - fmul(v2_tag.xnm, v2_tag.sel);
            r_t1_zt    <= v2_tag.zt;
            r_t1_elong <= v2_tag.elong;
            r_t1_phi   <= v2_ang;

            r_t2_xnt   <= fmul(r_t1_a, r_t1_zt) - r_t1_b;
            r_t2_ynt   <= r_t1_ynt;
            r_t2_elong <= r_t1_elong;
            r_t2_phi   <= r_t1_phi;
        end
    end

    t_tag3 w_tag3_in, v3_tag;
    t_vec  w_y3, w_x3;
    logic  v3_v;
    logic signed [ZW-1:0] v3_ang;

    assign w_y3 = -r_t2_ynt;
    assign w_x3 = -r_t2_xnt;
    assign w_tag3_in = '{elong: r_t2_elong, phi: r_t2_phi,
                         nz: ((r_t2_xnt != '0) || (r_t2_ynt != '0))};

    pmsc_cordic_vec #(.AW(AW), .STEPS(CORDIC_STEPS), .TW($bits(t_tag3))) u_vec_az (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_t2_v),
        .i_y     (w_y3),
        .i_x     (w_x3),
        .i_tag   (w_tag3_in),
        .o_valid (v3_v),
        .o_angle (v3_ang),
        .o_len   (),
        .o_tag   (v3_tag)
    );

    logic [95:0] r_tail;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tail <= {out_angle(v3_tag.nz ? v3_ang : '0),
                       out_angle(v3_tag.phi),
                       out_angle(v3_tag.elong)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v   <= 1'b0;
            r_p2_v   <= 1'b0;
            r_p3_v   <= 1'b0;
            r_q_v    <= 1'b0;
            r_t1_v   <= 1'b0;
            r_t2_v   <= 1'b0;
            r_tail_v <= 1'b0;
        end else if (en) begin
            r_p1_v   <= rot_v;
            r_p2_v   <= r_p1_v;
            r_p3_v   <= r_p2_v;
            r_q_v    <= v1_v;
            r_t1_v   <= v2_v;
            r_t2_v   <= r_t1_v;
            r_tail_v <= v3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_ov || i_m_axis_tready) begin
            if (r_skid_v) begin
                r_ov     <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_ov <= en && r_tail_v;
            end
        end else if (en && r_tail_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || i_m_axis_tready) begin
            r_odata <= r_skid_v ? r_skid : r_tail;
        end else if (en && r_tail_v) begin
            r_skid <= r_tail;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_odata;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_ov)
        else $error("skid holds an item while output is empty");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_m_axis_tready && r_tail_v && en) |=> r_skid_v)
        else $error("item from pipeline tail lost during output stall");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_m_axis_tready) |=> (r_ov && !r_skid_v))
        else $error("skid item not moved to output");
`endif

endmodule

FILE: sim/pmsc_checker.sv
`timescale 1ns / 100ps

module pmsc_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [127:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [95:0]  i_m_tdata,
    output int           o_fail_count,
    output int           o_pending
);

    localparam int NSTEP = 32;
    localparam longint QONE = 64'sd1 << 30;
    localparam longint GAIN = 64'sd652032874;
    localparam longint HALF_TURN = 64'sd1 << 31;
    localparam longint QUARTER_TURN = 64'sd1 << 30;

    typedef struct packed {
        logic [31:0] azimuth_correction;
        logic [31:0] true_latitude;
        logic [31:0] true_longitude;
    } t_site_fix;

    longint    arctan_turns [NSTEP];
    t_site_fix fix_queue [$];

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return floor_shift(a * b + (QONE >>> 1), 30);
    endfunction

    function automatic longint unsigned mulhi_q63(longint unsigned a, longint unsigned b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[126:63];
    endfunction

    function automatic void fill_arctan();
        longint unsigned acc;
        longint unsigned term;
        longint unsigned turns;
        for (int i = 0; i < NSTEP; i++) begin
            if (i == 0) begin
                turns = 64'd1 << 61;
            end else begin
                acc = 0;
                for (int k = 0; i * (2 * k + 1) <= 63; k++) begin
                    term = (64'd1 << (63 - i * (2 * k + 1))) / longint'(2 * k + 1);
                    if (k % 2 == 0) acc += term;
                    else acc -= term;
                end
                turns = mulhi_q63(acc, 64'h28BE60DB9391054A);
            end
            arctan_turns[i] = longint'((turns + (64'd1 << 31)) >> 32);
        end
    endfunction

    task automatic rotate_sincos(input longint ang, output longint sn, output longint cs);
        longint x, y, nx;
        bit     flip;
        x = GAIN;
        y = 0;
        flip = 0;
        if (ang > QUARTER_TURN) begin
            ang -= HALF_TURN;
            flip = 1;
        end else if (ang < -QUARTER_TURN) begin
            ang += HALF_TURN;
            flip = 1;
        end
        for (int i = 0; i < NSTEP; i++) begin
            if (ang >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); ang -= arctan_turns[i];
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); ang += arctan_turns[i];
            end
            x = nx;
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endtask

    task automatic vector_angle(input longint y, input longint x, output longint ang,
                                output longint mag);
        longint nx;
        ang = 0;
        if (x < 0) begin
            ang = (y >= 0) ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < NSTEP; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); y = y - (x >>> i); ang += arctan_turns[i];
            end else begin
                nx = x - (y >>> i); y = y + (x >>> i); ang -= arctan_turns[i];
            end
            x = nx;
        end
        mag = qmul(x, GAIN);
    endtask

    function automatic longint unit_ratio(longint n, longint d);
        longint unsigned m, q;
        m = (n < 0) ? -n : n;
        q = (m << 30) / longint'(d);
        if (q > QONE) q = QONE;
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    task automatic correct_site(input logic [127:0] d, output t_site_fix r);
        longint sel, cel, sph, cph, sxp, cxp, syp, cyp;
        longint xm, ym, zm, zw, xt, yt, zt, xnm, ynm, znm, xnt, ynt, len, junk;
        longint elong, phi, daz;
        elong = 0;
        daz = 0;
        rotate_sincos(longint'($signed(d[31:0])), sel, cel);
        rotate_sincos(longint'($signed(d[63:32])), sph, cph);
        rotate_sincos(longint'($signed(d[95:64])), sxp, cxp);
        rotate_sincos(longint'($signed(d[127:96])), syp, cyp);
        xm = qmul(cel, cph);
        ym = qmul(sel, cph);
        zm = sph;
        zw = qmul(zm, cyp) - qmul(ym, syp);
        xt = qmul(xm, cxp) - qmul(zw, sxp);
        yt = qmul(ym, cyp) + qmul(zm, syp);
        zt = qmul(xm, sxp) + qmul(zw, cxp);
        xnm = -qmul(sxp, cyp);
        ynm = syp;
        znm = qmul(cxp, cyp);
        if (xt != 0 || yt != 0) vector_angle(yt, xt, elong, len);
        else len = 0;
        if (len == 0) begin
            sel = 0;
            cel = QONE;
        end else begin
            sel = unit_ratio(yt, len);
            cel = unit_ratio(xt, len);
        end
        vector_angle(zt, len, phi, junk);
        xnt = qmul(qmul(xnm, cel) + qmul(ynm, sel), zt) - qmul(znm, len);
        ynt = qmul(ynm, cel) - qmul(xnm, sel);
        if (xnt != 0 || ynt != 0) vector_angle(-ynt, -xnt, daz, junk);
        r.true_longitude = elong[31:0];
        r.true_latitude = phi[31:0];
        r.azimuth_correction = daz[31:0];
    endtask

    initial begin
        fill_arctan();
    end

    always @(posedge i_clk) begin
        t_site_fix want, got;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                correct_site(i_s_tdata, want);
                fix_queue.push_back(want);
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (fix_queue.size() == 0) begin
                    $error("unexpected result item %h", i_m_tdata);
                    errs++;
                end else begin
                    want = fix_queue.pop_front();
                    if (got.true_longitude !== want.true_longitude) begin
                        $error("true_longitude exp %h got %h",
                               want.true_longitude, got.true_longitude);
                        errs++;
                    end
                    if (got.true_latitude !== want.true_latitude) begin
                        $error("true_latitude exp %h got %h",
                               want.true_latitude, got.true_latitude);
                        errs++;
                    end
                    if (got.azimuth_correction !== want.azimuth_correction) begin
                        $error("azimuth_correction exp %h got %h",
                               want.azimuth_correction, got.azimuth_correction);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            o_pending <= fix_queue.size();
        end
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int LATENCY = 177;
    localparam int IDLE_LIMIT = 5000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    int           fail_count;
    int           pending;
    int           idle_cycles;

    polar_motion_site_correction_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    pmsc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int phase;
        m_tready = 1'b0;
        phase = 0;
        @(negedge i_clk);
        forever begin
            @(negedge i_clk);
            phase++;
            case ((phase / 400) % 3)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ((phase % 7) < 2);
            endcase
        end
    end

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'($signed($urandom_range(0, 64)) - 32);
            4: return {$urandom_range(0, 7) * 32'h2000_0000} + $urandom_range(0, 2) - 1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_latitude();
        case ($urandom_range(0, 9))
            0: return 32'h4000_0000;
            1: return 32'hC000_0000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000);
        endcase
    endfunction

    task automatic send_site(input logic [31:0] lon, input logic [31:0] lat,
                             input logic [31:0] px, input logic [31:0] py);
        s_tdata <= {py, px, lat, lon};
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    initial begin
        int burst;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, poles, zero pole offsets, all-ones and half-turn patterns
        send_site(32'h0, 32'h0, 32'h0, 32'h0);
        send_site(32'h0, 32'h4000_0000, 32'h0, 32'h0);
        send_site(32'h0, 32'hC000_0000, 32'h0, 32'h0);
        send_site(32'h1234_5678, 32'h4000_0000, 32'h0, 32'h0);
        send_site(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_site(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_site(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_site(32'h4000_0000, 32'h0, 32'h4000_0000, 32'h0);
        send_site(32'h0, 32'h0, 32'h0, 32'h4000_0000);
        send_site(32'h0, 32'h0, 32'h4000_0000, 32'h4000_0000);
        send_site(32'hC000_0000, 32'h2000_0000, 32'hC000_0000, 32'hC000_0000);
        send_site(32'h2000_0000, 32'h1000_0000, 32'h0000_0100, 32'hFFFF_FF00);
        send_site(32'h0, 32'h3FFF_FFFF, 32'h0, 32'h1);
        send_site(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_site(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        s_tvalid <= 1'b0;

        for (int n = 0; n < 550; ) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && n < 550; b++, n++) begin
                send_site(pick_angle(), pick_latitude(), pick_angle(), pick_angle());
            end
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                s_tdata <= {$urandom, $urandom, $urandom, $urandom};
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0 && !m_tvalid) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: polar_motion_site_correction_top.f
design/pmsc_pkg.sv
design/pmsc_cordic_rot.sv
design/pmsc_cordic_vec.sv
design/pmsc_divider.sv
design/polar_motion_site_correction_top.sv
sim/pmsc_checker.sv
sim/testbench.sv
